// ===== rtl/core/trf_pkg.sv =====
// trf_pkg: shared types, register indexes, fill modes and clamps for the
// rectangle fill address generator. No dependencies.

package trf_pkg;

  localparam int SCREEN_SIDE      = 4096;
  localparam int MAX_TEXTURE_SIDE = 1024;

  localparam int CoordW   = 12;  // screen coordinate / offset width
  localparam int TexSizeW = 11;  // texture size register width
  localparam int TexIdxW  = 10;  // texture coordinate width
  localparam int ExtentW  = 13;  // rectangle extent, 1..4096
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int DivCntW  = 4;   // iterations of the divider, TexSizeW of them

  typedef enum logic [CfgIdxW-1:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_TEX_WIDTH   = 3'd4,
    REG_TEX_HEIGHT  = 3'd5,
    REG_FILL_MODE   = 3'd6,
    REG_MASK_ENABLE = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FILL_SOLID   = 2'd0,
    FILL_TILE    = 2'd1,
    FILL_STRETCH = 2'd2,
    FILL_UNUSED  = 2'd3
  } fill_mode_e;

  typedef enum logic [2:0] {
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic mask_bit;
  } mask_word_t;

  typedef struct packed {
    logic               draw_flag;
    logic [CoordW-1:0]  screen_x;
    logic [CoordW-1:0]  screen_y;
    logic [TexIdxW-1:0] tex_col;
    logic [TexIdxW-1:0] tex_row;
    logic               last_cell;
  } cell_word_t;

  typedef struct packed {
    logic div_start;
    logic div_sel_y;
    logic load_x;
    logic load_y;
    logic run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } ctrl_status_t;

  function automatic logic [CoordW-1:0] clamp_coord(logic [CoordW-1:0] v);
    logic [31:0] wide;
    wide = {{(32-CoordW){1'b0}}, v};
    if (wide > 32'(SCREEN_SIDE - 1)) return CoordW'(SCREEN_SIDE - 1);
    return v;
  endfunction

  function automatic logic [TexSizeW-1:0] clamp_tex(logic [TexSizeW-1:0] v);
    logic [31:0] wide;
    wide = {{(32-TexSizeW){1'b0}}, v};
    if (v == '0) return TexSizeW'(1);
    if (wide > 32'(MAX_TEXTURE_SIDE)) return TexSizeW'(MAX_TEXTURE_SIDE);
    return v;
  endfunction

endpackage

// ===== rtl/core/trf_stream_if.sv =====
// trf_stream_if: valid/ready channel carrying one payload word.
// Payload type is supplied by the instantiating level (see trf_pkg).

interface trf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/texture_rect_fill_address_gen.sv =====
// texture_rect_fill_address_gen: top level, rectangle scan with solid,
// tiled and stretched texture addressing. Uses trf_pkg, trf_stream_if,
// trf_ctrl and trf_datapath.
//
//   channel    dir   word             handshake
//   mask_in    in    mask_word_t      valid/ready
//   cell_out   out   cell_word_t      valid/ready
//   cfg_*      in    index + data     write enable, no stall
//
// One mask word in, one cell word out, one per clock while cell_out is ready; the
// output register lets a new word in while the previous cell is taken.
// After reset and after every register write the shared divider runs twice
// (texture width over rectangle width, then height over height), with
// mask_in.ready low. Reset is asynchronous, active low; a stalled cell_out
// holds its word and mask_in.ready drops with it.

module texture_rect_fill_address_gen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  trf_stream_if.sink                    mask_in,
  trf_stream_if.source                  cell_out
);

  trf_pkg::ctrl_cmd_t    cmd;
  trf_pkg::ctrl_status_t status;

  trf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .status_i (status),
    .cmd_o    (cmd)
  );

  trf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .mask_in     (mask_in),
    .cell_out    (cell_out)
  );

  // a register write restarts the step size preparation
  a_cfg_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !mask_in.ready
  ) else $error("mask word taken right after a register write");

  a_accept_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (mask_in.valid && mask_in.ready) |=> cell_out.valid
  ) else $error("accepted mask word produced no cell word");

  a_divider_idle_in_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !cmd.run
  ) else $error("divider finished while the scan was running");

endmodule

// ===== rtl/core/trf_divider.sv =====
// trf_divider: restoring divider, one quotient bit per cycle.
// Uses trf_pkg widths.

module trf_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [trf_pkg::TexSizeW-1:0]   dividend_i,
  input  logic [trf_pkg::ExtentW-1:0]    divisor_i,
  output logic                           done_o,
  output logic [trf_pkg::TexSizeW-1:0]   quotient_o,
  output logic [trf_pkg::ExtentW-1:0]    remainder_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [trf_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [trf_pkg::TexSizeW-1:0]  dvd_q, dvd_d;
  logic [trf_pkg::TexSizeW-1:0]  quo_q, quo_d;
  logic [trf_pkg::ExtentW-1:0]   rem_q, rem_d;
  logic [trf_pkg::ExtentW-1:0]   dvs_q, dvs_d;
  logic [trf_pkg::ExtentW:0]     trial;
  logic                          fits;

  assign trial = {rem_q, dvd_q[trf_pkg::TexSizeW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = trf_pkg::DivCntW'(trf_pkg::TexSizeW);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? trf_pkg::ExtentW'(trial - {1'b0, dvs_q})
                   : trial[trf_pkg::ExtentW-1:0];
      quo_d = {quo_q[trf_pkg::TexSizeW-2:0], fits};
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == trf_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/core/trf_ctrl.sv =====
// trf_ctrl: sequencer that prepares the stretch step sizes after reset or
// a register write, then lets the scan run. Uses trf_pkg.

module trf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  trf_pkg::ctrl_status_t status_i,
  output trf_pkg::ctrl_cmd_t    cmd_o
);

  trf_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = trf_pkg::ST_DIV_X;
    end else begin
      unique case (state_q)
        trf_pkg::ST_DIV_X:  state_d = trf_pkg::ST_WAIT_X;
        trf_pkg::ST_WAIT_X: if (status_i.div_done) state_d = trf_pkg::ST_DIV_Y;
        trf_pkg::ST_DIV_Y:  state_d = trf_pkg::ST_WAIT_Y;
        trf_pkg::ST_WAIT_Y: if (status_i.div_done) state_d = trf_pkg::ST_RUN;
        trf_pkg::ST_RUN:    state_d = trf_pkg::ST_RUN;
        default:            state_d = trf_pkg::ST_DIV_X;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_start = (state_q == trf_pkg::ST_DIV_X) || (state_q == trf_pkg::ST_DIV_Y);
    cmd_o.div_sel_y = (state_q == trf_pkg::ST_DIV_Y) || (state_q == trf_pkg::ST_WAIT_Y);
    cmd_o.load_x    = (state_q == trf_pkg::ST_WAIT_X) && status_i.div_done;
    cmd_o.load_y    = (state_q == trf_pkg::ST_WAIT_Y) && status_i.div_done;
    cmd_o.run       = (state_q == trf_pkg::ST_RUN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trf_pkg::ST_DIV_X;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/trf_datapath.sv =====
// trf_datapath: configuration registers, raster scan counters, tile and
// stretch coordinate steppers, output word register. Uses trf_pkg,
// trf_stream_if and trf_divider.

module trf_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [trf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [trf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  trf_pkg::ctrl_cmd_t             cmd_i,
  output trf_pkg::ctrl_status_t          status_o,
  trf_stream_if.sink                     mask_in,
  trf_stream_if.source                   cell_out
);

  localparam int CW = trf_pkg::CoordW;
  localparam int SW = trf_pkg::TexSizeW;
  localparam int TW = trf_pkg::TexIdxW;
  localparam int EW = trf_pkg::ExtentW;

  // configuration registers
  logic [CW-1:0] left_q, top_q, right_q, bottom_q;
  logic [SW-1:0] tex_w_q, tex_h_q;
  logic [1:0]    mode_q;
  logic          mask_en_q;

  // effective geometry
  logic [CW-1:0] l_eff, t_eff, r_eff, b_eff;
  logic [SW-1:0] tw_eff, th_eff;
  logic [EW-1:0] nx, ny;
  logic          degenerate;

  // scan state
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [TW-1:0] tcol_q, tcol_d, trow_q, trow_d;
  logic [TW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [CW-1:0] rx_q, rx_d, ry_q, ry_d;

  // stretch step sizes: size / extent as quotient and remainder
  logic [SW-1:0] quo_x_q, quo_y_q;
  logic [SW-1:0] rem_x_q, rem_y_q;

  // divider
  logic [SW-1:0] div_quo;
  logic [EW-1:0] div_rem;
  logic          div_done;

  // output register
  logic                valid_q, valid_d;
  trf_pkg::cell_word_t cell_q, cell_d;
  logic                accept;
  logic                last_col, last_row;

  // stepper intermediates
  logic [EW-1:0] sum_x, sum_y;
  logic          ge_x, ge_y;
  logic [SW-1:0] tcol_inc, trow_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      top_q     <= '0;
      right_q   <= '0;
      bottom_q  <= '0;
      tex_w_q   <= SW'(1);
      tex_h_q   <= SW'(1);
      mode_q    <= trf_pkg::FILL_SOLID;
      mask_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (trf_pkg::cfg_reg_e'(cfg_index_i))
        trf_pkg::REG_RECT_LEFT:   left_q    <= cfg_wdata_i;
        trf_pkg::REG_RECT_TOP:    top_q     <= cfg_wdata_i;
        trf_pkg::REG_RECT_RIGHT:  right_q   <= cfg_wdata_i;
        trf_pkg::REG_RECT_BOTTOM: bottom_q  <= cfg_wdata_i;
        trf_pkg::REG_TEX_WIDTH:   tex_w_q   <= cfg_wdata_i[SW-1:0];
        trf_pkg::REG_TEX_HEIGHT:  tex_h_q   <= cfg_wdata_i[SW-1:0];
        trf_pkg::REG_FILL_MODE:   mode_q    <= cfg_wdata_i[1:0];
        trf_pkg::REG_MASK_ENABLE: mask_en_q <= cfg_wdata_i[0];
        default:                  mask_en_q <= mask_en_q;
      endcase
    end
  end

  always_comb begin
    l_eff  = trf_pkg::clamp_coord(left_q);
    t_eff  = trf_pkg::clamp_coord(top_q);
    r_eff  = trf_pkg::clamp_coord(right_q);
    b_eff  = trf_pkg::clamp_coord(bottom_q);
    tw_eff = trf_pkg::clamp_tex(tex_w_q);
    th_eff = trf_pkg::clamp_tex(tex_h_q);
    // an inverted side collapses to one cell
    nx = (r_eff >= l_eff) ? EW'({1'b0, r_eff} - {1'b0, l_eff} + 1'b1) : EW'(1);
    ny = (b_eff >= t_eff) ? EW'({1'b0, b_eff} - {1'b0, t_eff} + 1'b1) : EW'(1);
    degenerate = (r_eff <= l_eff) || (b_eff <= t_eff);
  end

  trf_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (cmd_i.div_sel_y ? th_eff : tw_eff),
    .divisor_i   (cmd_i.div_sel_y ? ny : nx),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      quo_x_q <= div_quo;
      rem_x_q <= div_rem[SW-1:0];  // remainder is at most the texture size
    end
    if (cmd_i.load_y) begin
      quo_y_q <= div_quo;
      rem_y_q <= div_rem[SW-1:0];
    end
  end

  // handshake
  assign mask_in.ready = cmd_i.run && (!valid_q || cell_out.ready);
  assign accept        = mask_in.valid && mask_in.ready;

  assign last_col = ({1'b0, col_q} == EW'(nx - 1'b1));
  assign last_row = ({1'b0, row_q} == EW'(ny - 1'b1));

  // next stretch position: remainder grows by rem, wraps once it reaches the extent
  assign sum_x    = {1'b0, rx_q} + {{(EW-SW){1'b0}}, rem_x_q};
  assign sum_y    = {1'b0, ry_q} + {{(EW-SW){1'b0}}, rem_y_q};
  assign ge_x     = sum_x >= nx;
  assign ge_y     = sum_y >= ny;
  assign tcol_inc = {1'b0, tcol_q} + 1'b1;
  assign trow_inc = {1'b0, trow_q} + 1'b1;

  always_comb begin
    cell_d           = cell_q;
    cell_d.draw_flag = degenerate ? 1'b0 : (mask_en_q ? mask_in.data.mask_bit : 1'b1);
    cell_d.screen_x  = l_eff + col_q;
    cell_d.screen_y  = t_eff + row_q;
    unique case (trf_pkg::fill_mode_e'(mode_q))
      trf_pkg::FILL_TILE: begin
        cell_d.tex_col = tcol_q;
        cell_d.tex_row = trow_q;
      end
      trf_pkg::FILL_STRETCH: begin
        cell_d.tex_col = qx_q;
        cell_d.tex_row = qy_q;
      end
      default: begin
        cell_d.tex_col = '0;
        cell_d.tex_row = '0;
      end
    endcase
    cell_d.last_cell = last_col && last_row;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    tcol_d = tcol_q;
    trow_d = trow_q;
    qx_d   = qx_q;
    rx_d   = rx_q;
    qy_d   = qy_q;
    ry_d   = ry_q;
    if (cfg_we_i) begin
      col_d  = '0;
      row_d  = '0;
      tcol_d = '0;
      trow_d = '0;
      qx_d   = '0;
      rx_d   = '0;
      qy_d   = '0;
      ry_d   = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d  = '0;
        tcol_d = '0;
        qx_d   = '0;
        rx_d   = '0;
        if (last_row) begin
          row_d  = '0;
          trow_d = '0;
          qy_d   = '0;
          ry_d   = '0;
        end else begin
          row_d  = row_q + 1'b1;
          trow_d = (trow_inc >= th_eff) ? '0 : trow_inc[TW-1:0];
          ry_d   = ge_y ? CW'(sum_y - ny) : sum_y[CW-1:0];
          qy_d   = TW'({1'b0, qy_q} + quo_y_q + SW'(ge_y));
        end
      end else begin
        col_d  = col_q + 1'b1;
        tcol_d = (tcol_inc >= tw_eff) ? '0 : tcol_inc[TW-1:0];
        rx_d   = ge_x ? CW'(sum_x - nx) : sum_x[CW-1:0];
        qx_d   = TW'({1'b0, qx_q} + quo_x_q + SW'(ge_x));
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cell_out.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      tcol_q  <= '0;
      trow_q  <= '0;
      qx_q    <= '0;
      rx_q    <= '0;
      qy_q    <= '0;
      ry_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      tcol_q  <= tcol_d;
      trow_q  <= trow_d;
      qx_q    <= qx_d;
      rx_q    <= rx_d;
      qy_q    <= qy_d;
      ry_q    <= ry_d;
      valid_q <= valid_d;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q <= cell_d;
    end
  end

  assign cell_out.valid = valid_q;
  assign cell_out.data  = cell_q;

endmodule
